// ===== rtl/bem_pkg.sv =====
// bem_pkg: shared constants, status and command codes, state type and helpers
// for the bitmap element allocator. Used by every file in rtl/.
package bem_pkg;

    localparam int MAX_ELEMS     = 4096;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_WORDS     = MAX_ELEMS / MAP_WORD_BITS;
    localparam int ADDR_W        = $clog2(MAP_WORDS);
    localparam int BIT_W         = $clog2(MAP_WORD_BITS);
    localparam int IDX_W         = $clog2(MAX_ELEMS);
    localparam int CNT_W         = 13;
    localparam int SIZE_W        = 13;
    localparam int OFF_W         = 24;
    localparam int STATUS_W      = 3;
    localparam int CFG_INDEX_W   = 1;
    localparam int WCNT_W        = ADDR_W + 1;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_ELEM_SIZE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEM_COUNT = 1'd1;

    localparam logic [SIZE_W-1:0] ELEM_SIZE_RESET  = 13'd64;
    localparam logic [CNT_W-1:0]  ELEM_COUNT_RESET = 13'd4096;
    localparam logic [CNT_W-1:0]  CNT_CAP          = CNT_W'(MAX_ELEMS);
    localparam logic [CNT_W-1:0]  CNT_MAX          = '1;

    typedef logic [MAP_WORD_BITS-1:0] map_word_t;

    typedef struct packed {
        logic             en;
        logic [ADDR_W-1:0] addr;
        map_word_t        data;
    } map_wr_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_FREE_CHK,
        S_FINISH
    } state_t;

    // position of the lowest set bit, zero when none is set
    function automatic logic [BIT_W-1:0] lowest_set(input map_word_t v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (v[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/bem_map_ram.sv =====
// bem_map_ram: free bitmap store, one write and one registered read a cycle.
// Per-word valid bits make unwritten words read as all free. Uses bem_pkg.
module bem_map_ram
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [bem_pkg::ADDR_W-1:0] rd_addr,
    output bem_pkg::map_word_t         rd_data,
    input  bem_pkg::map_wr_t           wr
);

    bem_pkg::map_word_t             mem [bem_pkg::MAP_WORDS];
    bem_pkg::map_word_t             rd_word_reg;
    logic [bem_pkg::MAP_WORDS-1:0]  word_valid_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                word_valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= word_valid_reg[rd_addr];
            end
        end
    end

    // a word never written still holds its reset value, every element free
    assign rd_data = rd_valid_reg ? rd_word_reg : '1;

endmodule

// ===== rtl/bem_div.sv =====
// bem_div: restoring divider, one quotient bit per cycle, for offset / element size.
// Uses bem_pkg for widths.
module bem_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bem_pkg::OFF_W-1:0]  dividend,
    input  logic [bem_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output logic [bem_pkg::OFF_W-1:0]  quotient,
    output logic [bem_pkg::SIZE_W-1:0] remainder
);

    localparam int STEP_W = $clog2(bem_pkg::OFF_W);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [bem_pkg::SIZE_W-1:0] rem_reg, rem_next;
    logic [bem_pkg::OFF_W-1:0]  quo_reg, quo_next;
    logic [bem_pkg::SIZE_W-1:0] dvs_reg, dvs_next;
    logic [bem_pkg::SIZE_W:0]   trial;
    logic                       fits;

    assign trial = {rem_reg, quo_reg[bem_pkg::OFF_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits back in SIZE_W bits
            rem_next = fits ? bem_pkg::SIZE_W'(trial - {1'b0, dvs_reg})
                            : trial[bem_pkg::SIZE_W-1:0];
            quo_next = {quo_reg[bem_pkg::OFF_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(bem_pkg::OFF_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/bitmap_element_allocator.sv =====
// bitmap_element_allocator: first-fit element pool over a 64 x 64 free bitmap memory.
// Uses bem_pkg, bem_map_ram (bitmap store) and bem_div (offset divider).
//
//   channel  signals                                         direction
//   in       in_valid in_stall cmd elem_offset_in            request in, stall out
//   out      out_valid out_stall status elem_index           result out, stall in
//            elem_offset_out alloc_count
//   cfg      cfg_valid cfg_ready cfg_index cfg_data          register write in
//
// one request at a time; an allocate reads the bitmap one word a cycle, first fit, until
// it finds a word holding a free bit among the (at most 64) words covering the element
// count, or reports the pool full when they run out (at once for an empty pool).
// a free runs 24 divider steps, the quotient check, one bitmap read and the write-back;
// misaligned or out of range ends after the quotient check, zero element size at once.
// reset marks every bitmap word free through per-word valid bits, no clearing pass needed.
// a waiting result sits in the output register; a new request is taken meanwhile and
// completes as soon as that register drains.
module bitmap_element_allocator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic [bem_pkg::OFF_W-1:0]       elem_offset_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bem_pkg::STATUS_W-1:0]    status,
    output logic [bem_pkg::IDX_W-1:0]       elem_index,
    output logic [bem_pkg::OFF_W-1:0]       elem_offset_out,
    output logic [bem_pkg::CNT_W-1:0]       alloc_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bem_pkg::SIZE_W-1:0]      cfg_data
);

    bem_pkg::state_t                 state_reg, state_next;
    logic [bem_pkg::SIZE_W-1:0]      elem_size_reg;
    logic [bem_pkg::CNT_W-1:0]       elem_count_reg;
    logic [bem_pkg::CNT_W-1:0]       total_reg, total_next;
    logic                            cmd_reg, cmd_next;
    logic [bem_pkg::WCNT_W-1:0]      scan_reg, scan_next;
    logic                            pend_reg, pend_next;
    logic [bem_pkg::ADDR_W-1:0]      pend_word_reg, pend_word_next;
    logic [bem_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [bem_pkg::IDX_W-1:0]       res_idx_reg, res_idx_next;
    logic                            wr_pend_reg, wr_pend_next;
    logic [bem_pkg::ADDR_W-1:0]      wr_addr_reg, wr_addr_next;
    bem_pkg::map_word_t              wr_word_reg, wr_word_next;
    logic                            out_valid_reg, out_valid_next;
    logic [bem_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [bem_pkg::IDX_W-1:0]       index_reg, index_next;
    logic [bem_pkg::OFF_W-1:0]       offset_reg, offset_next;

    logic                            accept;
    logic                            out_free;
    logic [bem_pkg::CNT_W-1:0]       cnt;
    logic [bem_pkg::WCNT_W-1:0]      nwords;
    logic                            issue;
    bem_pkg::map_word_t              word_mask;
    bem_pkg::map_word_t              masked;
    logic [bem_pkg::BIT_W-1:0]       hit_bit;
    logic [bem_pkg::IDX_W+bem_pkg::SIZE_W-1:0] prod;

    logic                            rd_en;
    logic [bem_pkg::ADDR_W-1:0]      rd_addr;
    bem_pkg::map_word_t              rd_data;
    bem_pkg::map_wr_t                map_wr;

    logic                            div_start;
    logic                            div_done;
    logic [bem_pkg::OFF_W-1:0]       div_quo;
    logic [bem_pkg::SIZE_W-1:0]      div_rem;

    bem_map_ram u_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (map_wr)
    );

    bem_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (elem_offset_in),
        .divisor   (elem_size_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_stall  = state_reg != bem_pkg::S_IDLE;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // counts above capacity behave as the full pool
    assign cnt    = (elem_count_reg > bem_pkg::CNT_CAP) ? bem_pkg::CNT_CAP : elem_count_reg;
    assign nwords = cnt[bem_pkg::CNT_W-1:bem_pkg::BIT_W]
                  + bem_pkg::WCNT_W'(|cnt[bem_pkg::BIT_W-1:0]);
    assign issue  = scan_reg < nwords;

    // the word holding the pool end only searches bits below the count
    assign word_mask = ({1'b0, pend_word_reg} == cnt[bem_pkg::CNT_W-1:bem_pkg::BIT_W])
                     ? ((bem_pkg::map_word_t'(1) << cnt[bem_pkg::BIT_W-1:0])
                        - bem_pkg::map_word_t'(1))
                     : '1;
    assign masked    = rd_data & word_mask;
    assign hit_bit   = bem_pkg::lowest_set(masked);

    assign prod = {{bem_pkg::SIZE_W{1'b0}}, res_idx_reg}
                * {{bem_pkg::IDX_W{1'b0}}, elem_size_reg};

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        cmd_next        = cmd_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        pend_word_next  = pend_word_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        wr_word_next    = wr_word_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        index_next      = index_reg;
        offset_next     = offset_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        map_wr.en       = 1'b0;
        map_wr.addr     = wr_addr_reg;
        map_wr.data     = wr_word_reg;
        div_start       = 1'b0;

        case (state_reg)
            bem_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = cmd;
                    res_status_next = bem_pkg::ST_OK;
                    res_idx_next    = '0;
                    wr_pend_next    = 1'b0;
                    scan_next       = '0;
                    pend_next       = 1'b0;
                    if (cmd == bem_pkg::CMD_ALLOC)
                    begin
                        state_next = bem_pkg::S_SCAN;
                    end
                    else if (elem_size_reg == '0)
                    begin
                        res_status_next = bem_pkg::ST_MISALIGNED;
                        state_next      = bem_pkg::S_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = bem_pkg::S_DIV;
                    end
                end
            end

            bem_pkg::S_SCAN:
            begin
                // one word read issued per cycle, the previous one examined
                if (issue)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg[bem_pkg::ADDR_W-1:0];
                    scan_next = scan_reg + bem_pkg::WCNT_W'(1);
                end
                pend_next      = issue;
                pend_word_next = scan_reg[bem_pkg::ADDR_W-1:0];
                if (pend_reg && (masked != '0))
                begin
                    res_idx_next = {pend_word_reg, hit_bit};
                    wr_pend_next = 1'b1;
                    wr_addr_next = pend_word_reg;
                    wr_word_next = rd_data & ~(bem_pkg::map_word_t'(1) << hit_bit);
                    state_next   = bem_pkg::S_FINISH;
                end
                else if (!issue && !pend_reg)
                begin
                    res_status_next = bem_pkg::ST_FULL;
                    state_next      = bem_pkg::S_FINISH;
                end
            end

            bem_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    res_idx_next = div_quo[bem_pkg::IDX_W-1:0];
                    if (div_rem != '0)
                    begin
                        res_status_next = bem_pkg::ST_MISALIGNED;
                        state_next      = bem_pkg::S_FINISH;
                    end
                    else if (div_quo >= bem_pkg::OFF_W'(cnt))
                    begin
                        res_status_next = bem_pkg::ST_RANGE;
                        state_next      = bem_pkg::S_FINISH;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = div_quo[bem_pkg::IDX_W-1:bem_pkg::BIT_W];
                        state_next = bem_pkg::S_FREE_CHK;
                    end
                end
            end

            bem_pkg::S_FREE_CHK:
            begin
                if (rd_data[res_idx_reg[bem_pkg::BIT_W-1:0]])
                begin
                    res_status_next = bem_pkg::ST_ALREADY_FREE;
                end
                else
                begin
                    wr_pend_next = 1'b1;
                    wr_addr_next = res_idx_reg[bem_pkg::IDX_W-1:bem_pkg::BIT_W];
                    wr_word_next = rd_data
                                 | (bem_pkg::map_word_t'(1) << res_idx_reg[bem_pkg::BIT_W-1:0]);
                end
                state_next = bem_pkg::S_FINISH;
            end

            bem_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    map_wr.en      = wr_pend_reg;
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    index_next     = res_idx_reg;
                    offset_next    = '0;
                    if (wr_pend_reg && (cmd_reg == bem_pkg::CMD_ALLOC))
                    begin
                        offset_next = prod[bem_pkg::OFF_W-1:0];
                        if (total_reg != bem_pkg::CNT_MAX)
                        begin
                            total_next = total_reg + bem_pkg::CNT_W'(1);
                        end
                    end
                    else if (wr_pend_reg && (total_reg != '0))
                    begin
                        total_next = total_reg - bem_pkg::CNT_W'(1);
                    end
                    state_next = bem_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bem_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bem_pkg::S_IDLE;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            wr_pend_reg    <= 1'b0;
            elem_size_reg  <= bem_pkg::ELEM_SIZE_RESET;
            elem_count_reg <= bem_pkg::ELEM_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            wr_pend_reg   <= wr_pend_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bem_pkg::CFG_ELEM_SIZE:  elem_size_reg  <= cfg_data;
                    bem_pkg::CFG_ELEM_COUNT: elem_count_reg <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        scan_reg       <= scan_next;
        pend_word_reg  <= pend_word_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        wr_addr_reg    <= wr_addr_next;
        wr_word_reg    <= wr_word_next;
        status_reg     <= status_next;
        index_reg      <= index_next;
        offset_reg     <= offset_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign elem_index      = index_reg;
    assign elem_offset_out = offset_reg;
    assign alloc_count     = total_reg;

endmodule
